### rtl/qoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoa_pkg
// shared types for the quaternion orientation accumulator
// ----------------------------------------------------------------------------
package qoa_pkg;

    localparam int FieldW = 32;

    typedef struct packed {
        logic              load;
        logic [FieldW-1:0] in_x;
        logic [FieldW-1:0] in_y;
        logic [FieldW-1:0] in_z;
        logic [FieldW-1:0] in_w;
    } t_in;

    typedef struct packed {
        logic [FieldW-1:0] out_x;
        logic [FieldW-1:0] out_y;
        logic [FieldW-1:0] out_z;
        logic [FieldW-1:0] out_w;
        logic              saturated;
    } t_out;

    typedef struct packed {
        logic capture;
        logic do_load;
        logic mul_step;
        logic sq_step;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic mul_last;
        logic sq_last;
        logic sqrt_last;
        logic div_all_last;
    } t_sts;

endpackage

### rtl/qoa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoa_ctrl
// sequencer for product, sum of squares, square root and division
// ----------------------------------------------------------------------------
module qoa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_load,
    input  logic          i_out_free,
    input  qoa_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output qoa_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SQ, S_SQRT, S_DIV, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.do_load = i_load;
                    n_state = i_load ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_all_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/qoa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoa_dp
// datapath: hamilton product, sum of squares, bitwise sqrt, restoring divide
// ----------------------------------------------------------------------------
module qoa_dp #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qoa_pkg::t_in  i_in,
    input  qoa_pkg::t_cmd i_cmd,
    output qoa_pkg::t_sts o_sts,
    output qoa_pkg::t_out o_res
);

    localparam int W   = COMP_WIDTH;
    localparam int PW  = 2 * W + 2;
    localparam int MW0 = 2 * W - FRAC_BITS + 1;
    localparam int MW1 = (FRAC_BITS + 2 > W + 1) ? FRAC_BITS + 2 : W + 1;
    localparam int MW  = (MW0 > MW1) ? MW0 : MW1;
    localparam int SW  = 2 * MW;
    localparam int RW  = MW + 1;
    localparam int FW  = qoa_pkg::FieldW;
    localparam int SRW = $clog2(MW);
    localparam int DCW = $clog2(FRAC_BITS + 2);
    localparam logic signed [W-1:0] Hi = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] Lo = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] r_q [4];
    logic signed [W-1:0] r_b [4];
    logic signed [PW-1:0] r_acc;
    logic signed [MW-1:0] r_p [4];
    logic [4:0] r_mcnt;
    logic [1:0] r_k;
    logic [SW-1:0] r_s;
    logic [MW-1:0] r_m;
    logic [SRW-1:0] r_sbit;
    logic [RW-1:0] r_rem;
    logic [MW-1:0] r_quo;
    logic [DCW-1:0] r_dcnt;
    logic r_sat_in;
    logic r_sat;
    logic signed [W-1:0] r_res [4];
    logic r_res_sat;

    function automatic logic signed [W-1:0] f_clip(input logic [FW-1:0] v,
                                                   output logic sat);
        logic signed [FW-1:0] s;
        begin
            s = v;
            sat = 1'b0;
            f_clip = s[W-1:0];
            if (s > FW'(signed'(Hi))) begin
                sat = 1'b1;
                f_clip = Hi;
            end else if (s < FW'(signed'(Lo))) begin
                sat = 1'b1;
                f_clip = Lo;
            end
        end
    endfunction

    // product term selection: component r_mcnt[4:2], term r_mcnt[1:0]
    logic signed [W-1:0] n_a, n_bb;
    logic n_neg;
    always_comb begin
        n_a = r_q[3];
        n_bb = r_b[0];
        n_neg = 1'b0;
        case (r_mcnt[4:0])
            5'd0:  begin n_a = r_q[3]; n_bb = r_b[0]; end
            5'd1:  begin n_a = r_q[0]; n_bb = r_b[3]; end
            5'd2:  begin n_a = r_q[1]; n_bb = r_b[2]; end
            5'd3:  begin n_a = r_q[2]; n_bb = r_b[1]; n_neg = 1'b1; end
            5'd4:  begin n_a = r_q[3]; n_bb = r_b[1]; end
            5'd5:  begin n_a = r_q[1]; n_bb = r_b[3]; end
            5'd6:  begin n_a = r_q[2]; n_bb = r_b[0]; end
            5'd7:  begin n_a = r_q[0]; n_bb = r_b[2]; n_neg = 1'b1; end
            5'd8:  begin n_a = r_q[3]; n_bb = r_b[2]; end
            5'd9:  begin n_a = r_q[2]; n_bb = r_b[3]; end
            5'd10: begin n_a = r_q[0]; n_bb = r_b[1]; end
            5'd11: begin n_a = r_q[1]; n_bb = r_b[0]; n_neg = 1'b1; end
            5'd12: begin n_a = r_q[3]; n_bb = r_b[3]; end
            5'd13: begin n_a = r_q[0]; n_bb = r_b[0]; n_neg = 1'b1; end
            5'd14: begin n_a = r_q[1]; n_bb = r_b[1]; n_neg = 1'b1; end
            5'd15: begin n_a = r_q[2]; n_bb = r_b[2]; n_neg = 1'b1; end
            default: ;
        endcase
    end

    logic signed [2*W-1:0] r_prod;
    logic r_prod_neg;
    logic r_prod_v;
    logic signed [PW-1:0] n_term;
    logic signed [PW-1:0] n_acc;
    assign n_term = r_prod_neg ? -PW'(r_prod) : PW'(r_prod);
    assign n_acc = r_acc + n_term;

    logic [MW-1:0] n_pabs;
    logic [SW-1:0] r_sq;
    logic [SRW:0] r_sqc;
    assign n_pabs = r_p[r_k][MW-1] ? MW'(-r_p[r_k]) : MW'(r_p[r_k]);

    logic [MW-1:0] n_cand;
    logic [SW-1:0] r_csq;
    logic r_sqph;
    assign n_cand = r_m | (MW'(1) << r_sbit);

    logic [MW-1:0] n_dabs;
    logic [RW-1:0] n_rem2;
    logic signed [MW-1:0] n_sq;
    logic signed [W-1:0] n_dv;
    logic n_dsat;
    assign n_dabs = r_p[r_k][MW-1] ? MW'(-r_p[r_k]) : MW'(r_p[r_k]);
    assign n_rem2 = {r_rem[RW-2:0], 1'b0};

    logic [RW-1:0] n_rsub;
    logic n_ge;
    assign n_ge = n_rem2 >= RW'(r_m);
    assign n_rsub = n_ge ? n_rem2 - RW'(r_m) : n_rem2;

    always_comb begin
        logic [MW-1:0] q;
        q = {r_quo[MW-2:0], n_ge};
        n_sq = r_p[r_k][MW-1] ? -signed'(q) : signed'(q);
        n_dsat = 1'b0;
        n_dv = n_sq[W-1:0];
        if (n_sq > MW'(signed'(Hi))) begin
            n_dsat = 1'b1;
            n_dv = Hi;
        end else if (n_sq < MW'(signed'(Lo))) begin
            n_dsat = 1'b1;
            n_dv = Lo;
        end
    end

    assign o_sts.mul_last     = r_prod_v && r_mcnt == 5'd16 && !r_sqph;
    assign o_sts.sq_last      = r_sqc == (SRW+1)'(4);
    assign o_sts.sqrt_last    = r_sqph && r_sbit == '0;
    assign o_sts.div_all_last = (r_dcnt == DCW'(FRAC_BITS) && r_k == 2'd3) || r_m == '0;

    always_ff @(posedge i_clk) begin
        logic s0, s1, s2, s3;
        logic signed [W-1:0] c0, c1, c2, c3;
        if (i_cmd.capture) begin
            c0 = f_clip(i_in.in_x, s0);
            c1 = f_clip(i_in.in_y, s1);
            c2 = f_clip(i_in.in_z, s2);
            c3 = f_clip(i_in.in_w, s3);
            r_b[0] <= c0; r_b[1] <= c1; r_b[2] <= c2; r_b[3] <= c3;
            r_sat_in <= s0 | s1 | s2 | s3;
            r_mcnt <= '0;
            r_prod_v <= 1'b0;
            r_acc <= '0;
            r_sqph <= 1'b0;
            r_sqc <= '0;
            r_k <= '0;
            r_s <= '0;
            if (i_cmd.do_load) begin
                r_p[0] <= MW'(c0); r_p[1] <= MW'(c1);
                r_p[2] <= MW'(c2); r_p[3] <= MW'(c3);
                r_m <= '0;
            end
        end
        if (i_cmd.mul_step) begin
            if (r_mcnt != 5'd16) begin
                r_prod <= n_a * n_bb;
                r_prod_neg <= n_neg;
                r_mcnt <= r_mcnt + 5'd1;
            end
            r_prod_v <= r_mcnt != 5'd16;
            if (r_prod_v) begin
                if (r_mcnt[1:0] == 2'd0) begin
                    r_p[2'(r_mcnt[4:2] - 3'd1)] <= MW'(n_acc >>> FRAC_BITS);
                    r_acc <= '0;
                end else begin
                    r_acc <= n_acc;
                end
            end
        end
        if (i_cmd.sq_step) begin
            r_sqc <= r_sqc + (SRW+1)'(1);
            if (r_sqc < (SRW+1)'(4)) begin
                r_sq <= SW'(n_pabs) * SW'(n_pabs);
                r_k <= r_k + 2'd1;
            end
            if (r_sqc != '0) r_s <= r_s + r_sq;
        end
        if (i_cmd.sqrt_init || (i_cmd.sqrt_step && r_sqph)) begin
            r_sqph <= 1'b0;
        end
        if (i_cmd.sqrt_init) begin
            r_m <= '0;
            r_sbit <= SRW'(MW - 1);
        end
        if (i_cmd.sqrt_step) begin
            if (!r_sqph) begin
                r_csq <= SW'(n_cand) * SW'(n_cand);
                r_sqph <= 1'b1;
            end else begin
                if (r_csq <= r_s) r_m <= n_cand;
                r_sbit <= r_sbit - SRW'(1);
            end
        end
        if (i_cmd.div_init) begin
            r_k <= '0;
            r_dcnt <= '0;
            r_sat <= 1'b0;
        end
        if (i_cmd.div_step && r_m != '0) begin
            if (r_dcnt == '0) begin
                r_rem <= n_dabs >= r_m ? RW'(n_dabs - r_m) : RW'(n_dabs);
                r_quo <= MW'(n_dabs >= r_m);
                r_dcnt <= r_dcnt + DCW'(1);
            end else begin
                r_rem <= n_rsub;
                r_quo <= {r_quo[MW-2:0], n_ge};
                if (r_dcnt == DCW'(FRAC_BITS)) begin
                    r_p[r_k] <= MW'(n_dv);
                    r_sat <= r_sat | n_dsat;
                    r_k <= r_k + 2'd1;
                    r_dcnt <= '0;
                end else begin
                    r_dcnt <= r_dcnt + DCW'(1);
                end
            end
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < 4; i++) begin
                r_q[i] <= r_p[i][W-1:0];
                r_res[i] <= r_p[i][W-1:0];
            end
            r_res_sat <= r_sat_in | (r_sat & (r_m != '0));
        end
        if (!i_rst_n) begin
            r_q[0] <= '0; r_q[1] <= '0; r_q[2] <= '0;
            r_q[3] <= (FRAC_BITS >= W - 1) ? Hi : W'(1) << FRAC_BITS;
        end
    end

    assign o_res.out_x = FW'(r_res[0]);
    assign o_res.out_y = FW'(r_res[1]);
    assign o_res.out_z = FW'(r_res[2]);
    assign o_res.out_w = FW'(r_res[3]);
    assign o_res.saturated = r_res_sat;

endmodule

### rtl/quaternion_orientation_accumulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_orientation_accumulator_core
// running orientation quaternion with hamilton product and renormalization
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// input   | in        | i_in_valid/o_in_ready | i_in  (qoa_pkg::t_in)
// result  | out       | o_out_valid/i_out_ready | o_out (qoa_pkg::t_out)
//
// load item: goes straight to commit; multiply item: product, sum of squares, serial
// square root (candidate squared, then compared, per bit; the larger of
// 2*COMP_WIDTH-FRAC_BITS+1, FRAC_BITS+2 and COMP_WIDTH+1 bits) and restoring divider
// (FRAC_BITS+1 quotient bits per component, four components); zero magnitude skips it
// a finished item commits once the output register is free
// synchronous active-low reset restores the identity quaternion
// ----------------------------------------------------------------------------
module quaternion_orientation_accumulator_core #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qoa_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output qoa_pkg::t_out o_out
);

    qoa_pkg::t_cmd w_cmd;
    qoa_pkg::t_sts w_sts;
    logic r_out_valid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    qoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_load     (i_in.load),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    qoa_dp #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/qoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoa_checker
// port-level checks for the orientation accumulator
// ----------------------------------------------------------------------------
module qoa_port_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input qoa_pkg::t_out o_out
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed under stall");

    // no new transfer accepted right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // a result never appears in the cycle after an input transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result too early");

    // after reset nothing is pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind quaternion_orientation_accumulator_core qoa_port_checker u_qoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
